// ----- hdl/mcfp_pkg.sv -----
package mcfp_pkg;

   localparam int CMD_W     = 32;
   localparam int LIMIT_W   = 31;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;
   localparam int POS_BITS  = 16;
   localparam int GAIN_BITS = 12;
   localparam int DIV_STEPS = POS_BITS;
   localparam int SPAN_W    = LIMIT_W + 2;
   localparam int REM_W     = SPAN_W + POS_BITS;
   localparam int LANE_STAGES = DIV_STEPS + 2;

   localparam logic [LIMIT_W-1:0] POSITION_LIMIT_RST  = LIMIT_W'(819200);
   localparam logic [LIMIT_W-1:0] VELOCITY_LIMIT_RST  = LIMIT_W'(4259840);
   localparam logic [LIMIT_W-1:0] STIFFNESS_LIMIT_RST = LIMIT_W'(32768000);
   localparam logic [LIMIT_W-1:0] DAMPING_LIMIT_RST   = LIMIT_W'(327680);
   localparam logic [LIMIT_W-1:0] TORQUE_LIMIT_RST    = LIMIT_W'(1179648);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_POSITION_LIMIT  = 3'd0,
      REG_VELOCITY_LIMIT  = 3'd1,
      REG_STIFFNESS_LIMIT = 3'd2,
      REG_DAMPING_LIMIT   = 3'd3,
      REG_TORQUE_LIMIT    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [POS_BITS-1:0]  position;
      logic [GAIN_BITS-1:0] velocity;
      logic [GAIN_BITS-1:0] stiffness;
      logic [GAIN_BITS-1:0] damping;
      logic [GAIN_BITS-1:0] torque;
   } codes_type;

   typedef struct packed {
      logic position;
      logic velocity;
      logic stiffness;
      logic damping;
      logic torque;
   } zero_flags_type;

endpackage

// ----- hdl/motor_command_frame_packer_core.sv -----
// Packs one motor command per beat into the eight-byte actuator command frame. Five lanes clamp
// and quantise position, velocity, stiffness, damping and torque side by side, each through a
// restoring divider of one quotient bit per stage, and a merge stage packs the codes. A command
// passes through clamp, scale, 16 divider stages and pack on its way to the result beat, and
// a new command is accepted every cycle while the result side keeps up. Limits must only be
// written while no command is in flight.
module motor_command_frame_packer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [mcfp_pkg::CMD_W-1:0]     req_position_cmd,
   input  logic signed [mcfp_pkg::CMD_W-1:0]     req_velocity_cmd,
   input  logic signed [mcfp_pkg::CMD_W-1:0]     req_stiffness_cmd,
   input  logic signed [mcfp_pkg::CMD_W-1:0]     req_damping_cmd,
   input  logic signed [mcfp_pkg::CMD_W-1:0]     req_torque_cmd,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_frame_byte_0,
   output logic [7:0]                            rsp_frame_byte_1,
   output logic [7:0]                            rsp_frame_byte_2,
   output logic [7:0]                            rsp_frame_byte_3,
   output logic [7:0]                            rsp_frame_byte_4,
   output logic [7:0]                            rsp_frame_byte_5,
   output logic [7:0]                            rsp_frame_byte_6,
   output logic [7:0]                            rsp_frame_byte_7,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mcfp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mcfp_pkg::CSR_DAT_W-1:0]        csr_data
);
   import mcfp_pkg::*;

   localparam int TOTAL = LANE_STAGES + 1;

   logic [LIMIT_W-1:0]     pos_lim_ff;
   logic [LIMIT_W-1:0]     vel_lim_ff;
   logic [LIMIT_W-1:0]     kp_lim_ff;
   logic [LIMIT_W-1:0]     kd_lim_ff;
   logic [LIMIT_W-1:0]     trq_lim_ff;
   logic [TOTAL-1:0]       valid_ff;
   logic [TOTAL-1:0]       valid_in;
   logic [TOTAL:0]         rdy;
   logic [TOTAL-1:0]       load;
   logic [DIV_STEPS-1:0]   pos_q;
   logic [DIV_STEPS-1:0]   vel_q;
   logic [DIV_STEPS-1:0]   kp_q;
   logic [DIV_STEPS-1:0]   kd_q;
   logic [DIV_STEPS-1:0]   trq_q;
   codes_type              codes;
   zero_flags_type         zero;

   assign csr_ready = 1'b1;

   always_comb begin
      rdy[TOTAL] = !rsp_stall;
      for (int k = TOTAL - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      load[0] = req_valid && rdy[0];
      for (int k = 1; k < TOTAL; k++) begin
         load[k] = valid_ff[k-1] && rdy[k];
      end
      for (int k = 0; k < TOTAL; k++) begin
         valid_in[k] = load[k] || (valid_ff[k] && !rdy[k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         pos_lim_ff <= POSITION_LIMIT_RST;
         vel_lim_ff <= VELOCITY_LIMIT_RST;
         kp_lim_ff  <= STIFFNESS_LIMIT_RST;
         kd_lim_ff  <= DAMPING_LIMIT_RST;
         trq_lim_ff <= TORQUE_LIMIT_RST;
      end else begin
         valid_ff <= valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               REG_POSITION_LIMIT:  pos_lim_ff <= csr_data[LIMIT_W-1:0];
               REG_VELOCITY_LIMIT:  vel_lim_ff <= csr_data[LIMIT_W-1:0];
               REG_STIFFNESS_LIMIT: kp_lim_ff  <= csr_data[LIMIT_W-1:0];
               REG_DAMPING_LIMIT:   kd_lim_ff  <= csr_data[LIMIT_W-1:0];
               REG_TORQUE_LIMIT:    trq_lim_ff <= csr_data[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   mcfp_lane #(.CODE_BITS(POS_BITS), .SYMMETRIC(1'b1)) u_pos (
      .clock(clock), .load(load[LANE_STAGES-1:0]), .cmd(req_position_cmd),
      .limit(pos_lim_ff), .code(pos_q));
   mcfp_lane #(.CODE_BITS(GAIN_BITS), .SYMMETRIC(1'b1)) u_vel (
      .clock(clock), .load(load[LANE_STAGES-1:0]), .cmd(req_velocity_cmd),
      .limit(vel_lim_ff), .code(vel_q));
   mcfp_lane #(.CODE_BITS(GAIN_BITS), .SYMMETRIC(1'b0)) u_kp (
      .clock(clock), .load(load[LANE_STAGES-1:0]), .cmd(req_stiffness_cmd),
      .limit(kp_lim_ff), .code(kp_q));
   mcfp_lane #(.CODE_BITS(GAIN_BITS), .SYMMETRIC(1'b0)) u_kd (
      .clock(clock), .load(load[LANE_STAGES-1:0]), .cmd(req_damping_cmd),
      .limit(kd_lim_ff), .code(kd_q));
   mcfp_lane #(.CODE_BITS(GAIN_BITS), .SYMMETRIC(1'b1)) u_trq (
      .clock(clock), .load(load[LANE_STAGES-1:0]), .cmd(req_torque_cmd),
      .limit(trq_lim_ff), .code(trq_q));

   always_comb begin
      codes.position  = pos_q;
      codes.velocity  = vel_q[GAIN_BITS-1:0];
      codes.stiffness = kp_q[GAIN_BITS-1:0];
      codes.damping   = kd_q[GAIN_BITS-1:0];
      codes.torque    = trq_q[GAIN_BITS-1:0];
      zero.position   = (pos_lim_ff == '0);
      zero.velocity   = (vel_lim_ff == '0);
      zero.stiffness  = (kp_lim_ff == '0);
      zero.damping    = (kd_lim_ff == '0);
      zero.torque     = (trq_lim_ff == '0);
   end

   mcfp_merge u_merge (
      .clock(clock), .load(load[TOTAL-1]), .codes(codes), .zero(zero),
      .frame_byte_0(rsp_frame_byte_0), .frame_byte_1(rsp_frame_byte_1),
      .frame_byte_2(rsp_frame_byte_2), .frame_byte_3(rsp_frame_byte_3),
      .frame_byte_4(rsp_frame_byte_4), .frame_byte_5(rsp_frame_byte_5),
      .frame_byte_6(rsp_frame_byte_6), .frame_byte_7(rsp_frame_byte_7));

   assign req_stall = !rdy[0];
   assign rsp_valid = valid_ff[TOTAL-1];

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted beat did not enter the first stage");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result beat was dropped");

   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) |-> (req_stall == rsp_stall))
      else $error("full pipeline does not pass back pressure");

   a_free_slot_accepts: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> !req_stall)
      else $error("empty first stage refused a beat");

endmodule

// ----- hdl/mcfp_lane.sv -----
module mcfp_lane #(
   parameter int CODE_BITS = mcfp_pkg::GAIN_BITS,
   parameter bit SYMMETRIC = 1'b1
) (
   input  logic                                 clock,
   input  logic [mcfp_pkg::LANE_STAGES-1:0]     load,
   input  logic signed [mcfp_pkg::CMD_W-1:0]    cmd,
   input  logic [mcfp_pkg::LIMIT_W-1:0]         limit,
   output logic [mcfp_pkg::DIV_STEPS-1:0]       code
);
   import mcfp_pkg::*;

   localparam int XW = CMD_W + 2;

   logic signed [XW-1:0]   cmd_x;
   logic signed [XW-1:0]   lo_x;
   logic signed [XW-1:0]   hi_x;
   logic signed [XW-1:0]   clamp_x;
   logic signed [XW-1:0]   diff_x;
   logic [SPAN_W-1:0]      span;
   logic [SPAN_W-1:0]      offs_in;
   logic [SPAN_W-1:0]      offs_ff;
   logic [REM_W-1:0]       prod_in;
   logic [REM_W-1:0]       prod_ff;
   logic [REM_W-1:0]       rem_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0]   quo_ff [DIV_STEPS];
   logic [REM_W-1:0]       rem_in [DIV_STEPS];
   logic [DIV_STEPS-1:0]   quo_in [DIV_STEPS];

   always_comb begin
      cmd_x = XW'(cmd);
      hi_x  = $signed({{(XW-LIMIT_W){1'b0}}, limit});
      lo_x  = SYMMETRIC ? -hi_x : '0;
      span  = SYMMETRIC ? {1'b0, limit, 1'b0} : {2'b00, limit};
      if (cmd_x < lo_x) begin
         clamp_x = lo_x;
      end else if (cmd_x > hi_x) begin
         clamp_x = hi_x;
      end else begin
         clamp_x = cmd_x;
      end
      diff_x  = clamp_x - lo_x;
      offs_in = diff_x[SPAN_W-1:0];
      prod_in = (REM_W'(offs_ff) << CODE_BITS) - REM_W'(offs_ff);
   end

   always_comb begin
      logic [REM_W-1:0]     r;
      logic [DIV_STEPS-1:0] q;
      logic [REM_W-1:0]     trial;
      for (int j = 0; j < DIV_STEPS; j++) begin
         r     = (j == 0) ? prod_ff : rem_ff[(j == 0) ? 0 : j-1];
         q     = (j == 0) ? '0 : quo_ff[(j == 0) ? 0 : j-1];
         trial = REM_W'(span) << (DIV_STEPS - 1 - j);
         if (r >= trial) begin
            r = r - trial;
            q[DIV_STEPS-1-j] = 1'b1;
         end
         rem_in[j] = r;
         quo_in[j] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         offs_ff <= offs_in;
      end
      if (load[1]) begin
         prod_ff <= prod_in;
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (load[j+2]) begin
            rem_ff[j] <= rem_in[j];
            quo_ff[j] <= quo_in[j];
         end
      end
   end

   assign code = quo_ff[DIV_STEPS-1];

endmodule

// ----- hdl/mcfp_merge.sv -----
module mcfp_merge (
   input  logic                     clock,
   input  logic                     load,
   input  mcfp_pkg::codes_type      codes,
   input  mcfp_pkg::zero_flags_type zero,
   output logic [7:0]               frame_byte_0,
   output logic [7:0]               frame_byte_1,
   output logic [7:0]               frame_byte_2,
   output logic [7:0]               frame_byte_3,
   output logic [7:0]               frame_byte_4,
   output logic [7:0]               frame_byte_5,
   output logic [7:0]               frame_byte_6,
   output logic [7:0]               frame_byte_7
);
   import mcfp_pkg::*;

   logic [POS_BITS-1:0]  p;
   logic [GAIN_BITS-1:0] v;
   logic [GAIN_BITS-1:0] kp;
   logic [GAIN_BITS-1:0] kd;
   logic [GAIN_BITS-1:0] t;
   logic [63:0]          frame_in;
   logic [63:0]          frame_ff;

   always_comb begin
      p  = zero.position  ? '0 : codes.position;
      v  = zero.velocity  ? '0 : codes.velocity;
      kp = zero.stiffness ? '0 : codes.stiffness;
      kd = zero.damping   ? '0 : codes.damping;
      t  = zero.torque    ? '0 : codes.torque;
      frame_in = {p, v, kp, kd, t};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= frame_in;
      end
   end

   assign frame_byte_0 = frame_ff[63:56];
   assign frame_byte_1 = frame_ff[55:48];
   assign frame_byte_2 = frame_ff[47:40];
   assign frame_byte_3 = frame_ff[39:32];
   assign frame_byte_4 = frame_ff[31:24];
   assign frame_byte_5 = frame_ff[23:16];
   assign frame_byte_6 = frame_ff[15:8];
   assign frame_byte_7 = frame_ff[7:0];

endmodule

// ----- verif/motor_command_frame_packer_core_tb.sv -----
module motor_command_frame_packer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mcfp_pkg::*;

   localparam int LATENCY     = 19;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic signed [CMD_W-1:0] position;
      logic signed [CMD_W-1:0] velocity;
      logic signed [CMD_W-1:0] stiffness;
      logic signed [CMD_W-1:0] damping;
      logic signed [CMD_W-1:0] torque;
   } command_type;

   typedef logic [63:0] frame_type;

   typedef struct {
      command_type cmd;
      bit          typed;
      frame_type   frame;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CMD_W-1:0] req_position_cmd = '0;
   logic signed [CMD_W-1:0] req_velocity_cmd = '0;
   logic signed [CMD_W-1:0] req_stiffness_cmd = '0;
   logic signed [CMD_W-1:0] req_damping_cmd = '0;
   logic signed [CMD_W-1:0] req_torque_cmd = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_frame_byte_0, rsp_frame_byte_1, rsp_frame_byte_2, rsp_frame_byte_3;
   logic [7:0] rsp_frame_byte_4, rsp_frame_byte_5, rsp_frame_byte_6, rsp_frame_byte_7;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   motor_command_frame_packer_core u_top (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   logic [LIMIT_W-1:0] lim_position, lim_velocity, lim_stiffness, lim_damping, lim_torque;
   frame_type expected_frames[$];
   int  mismatches = 0;
   int  frames_seen = 0;
   int  cycles = 0;
   bit  quiet_tail = 1'b0;

   function automatic logic [15:0] quantise(logic signed [CMD_W-1:0] value,
                                            logic [LIMIT_W-1:0] lim, bit symmetric,
                                            int bits);
      longint lo, hi, x, span, full;
      lo   = symmetric ? -longint'(lim) : 0;
      hi   = longint'(lim);
      x    = longint'(value);
      span = hi - lo;
      full = (longint'(1) << bits) - 1;
      if (span == 0) return '0;
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      return 16'(((x - lo) * full) / span);
   endfunction

   function automatic frame_type pack_frame(command_type c);
      logic [15:0] p, v, kp, kd, t;
      p  = quantise(c.position, lim_position, 1, POS_BITS);
      v  = quantise(c.velocity, lim_velocity, 1, GAIN_BITS);
      kp = quantise(c.stiffness, lim_stiffness, 0, GAIN_BITS);
      kd = quantise(c.damping, lim_damping, 0, GAIN_BITS);
      t  = quantise(c.torque, lim_torque, 1, GAIN_BITS);
      return {p[15:0], v[11:0], kp[11:0], kd[11:0], t[11:0]};
   endfunction

   task automatic write_limit(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_POSITION_LIMIT:  lim_position  = value[LIMIT_W-1:0];
         REG_VELOCITY_LIMIT:  lim_velocity  = value[LIMIT_W-1:0];
         REG_STIFFNESS_LIMIT: lim_stiffness = value[LIMIT_W-1:0];
         REG_DAMPING_LIMIT:   lim_damping   = value[LIMIT_W-1:0];
         REG_TORQUE_LIMIT:    lim_torque    = value[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all_limits(logic [CSR_DAT_W-1:0] p, logic [CSR_DAT_W-1:0] v,
                                   logic [CSR_DAT_W-1:0] kp, logic [CSR_DAT_W-1:0] kd,
                                   logic [CSR_DAT_W-1:0] t);
      write_limit(REG_POSITION_LIMIT, p);
      write_limit(REG_VELOCITY_LIMIT, v);
      write_limit(REG_STIFFNESS_LIMIT, kp);
      write_limit(REG_DAMPING_LIMIT, kd);
      write_limit(REG_TORQUE_LIMIT, t);
   endtask

   task automatic send_command(command_type c, bit typed, frame_type frame);
      int gap;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_position_cmd  <= c.position;
      req_velocity_cmd  <= c.velocity;
      req_stiffness_cmd <= c.stiffness;
      req_damping_cmd   <= c.damping;
      req_torque_cmd    <= c.torque;
      expected_frames.push_back(typed ? frame : pack_frame(c));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic signed [CMD_W-1:0] random_value(logic [LIMIT_W-1:0] lim);
      longint l;
      l = longint'(lim);
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return CMD_W'(l);
         2: return CMD_W'(-l);
         3: return CMD_W'(longint'($urandom_range(0, 32'hFFFF_FFFF)) % (2 * l + 1) - l);
         default: return CMD_W'(($urandom % (l + 1)) * (($urandom_range(0, 1)) ? 1 : -1));
      endcase
   endfunction

   function automatic command_type random_command();
      command_type c;
      c.position  = random_value(lim_position);
      c.velocity  = random_value(lim_velocity);
      c.stiffness = random_value(lim_stiffness);
      c.damping   = random_value(lim_damping);
      c.torque    = random_value(lim_torque);
      return c;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset || quiet_tail) rsp_stall <= 1'b0;
      else if (rsp_stall) rsp_stall <= ($urandom_range(0, 2) != 0);
      else rsp_stall <= ($urandom_range(0, 6) == 0);
      if (!reset && rsp_valid && !rsp_stall) begin
         frame_type got, want;
         got = {rsp_frame_byte_0, rsp_frame_byte_1, rsp_frame_byte_2, rsp_frame_byte_3,
                rsp_frame_byte_4, rsp_frame_byte_5, rsp_frame_byte_6, rsp_frame_byte_7};
         frames_seen++;
         if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected frame %h", got);
         end else begin
            want = expected_frames.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("Frame mismatch: expected %h, got %h", want, got);
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timed out with %0d frames outstanding.", expected_frames.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   stim_row_type directed[$];

   function automatic stim_row_type row(logic signed [CMD_W-1:0] p, logic signed [CMD_W-1:0] v,
                                        logic signed [CMD_W-1:0] kp,
                                        logic signed [CMD_W-1:0] kd,
                                        logic signed [CMD_W-1:0] t, bit typed,
                                        frame_type frame);
      stim_row_type r;
      r.cmd   = '{p, v, kp, kd, t};
      r.typed = typed;
      r.frame = frame;
      return r;
   endfunction

   initial begin
      lim_position  = POSITION_LIMIT_RST;
      lim_velocity  = VELOCITY_LIMIT_RST;
      lim_stiffness = STIFFNESS_LIMIT_RST;
      lim_damping   = DAMPING_LIMIT_RST;
      lim_torque    = TORQUE_LIMIT_RST;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // All values at their upper bound give all-ones codes; at or below the low bound, zero.
      directed.push_back(row(819200, 4259840, 32768000, 327680, 1179648, 1,
                             64'hFFFF_FFFF_FFFF_FFFF));
      directed.push_back(row(-819200, -4259840, 0, 0, -1179648, 1, 64'h0));
      directed.push_back(row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 1, 64'hFFFF_FFFF_FFFF_FFFF));
      directed.push_back(row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 1, 64'h0));
      directed.push_back(row(0, 0, 0, 0, 0, 0, '0));
      directed.push_back(row(-1, 1, 1, -1, 65536, 0, '0));
      directed.push_back(row(32'h5555_5555, 32'hAAAA_AAAA, 16384000, 163840, -589824, 0, '0));
      foreach (directed[i]) send_command(directed[i].cmd, directed[i].typed, directed[i].frame);
      wait_drained();

      // Zero limits everywhere give zero codes, and a write to an unknown index is ignored.
      write_all_limits(0, 0, 0, 0, 0);
      write_limit(REG_UNUSED, 32'h1234_5678);
      send_command('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 5, -5}, 1, 64'h0);
      send_command('{0, 0, 0, 0, 0}, 1, 64'h0);
      wait_drained();

      // Wide writes keep only the low 31 bits, so the limits become the largest allowed.
      write_all_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF);
      send_command('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF}, 1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_command('{32'h8000_0000, 32'h8000_0001, 32'h8000_0000, 0, 32'h8000_0001}, 1,
                   64'h0);
      send_command('{0, 1, 32'h4000_0000, 32'h1234_5678, -2}, 0, '0);
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_all_limits(POSITION_LIMIT_RST, VELOCITY_LIMIT_RST, STIFFNESS_LIMIT_RST,
                                DAMPING_LIMIT_RST, TORQUE_LIMIT_RST);
            1: write_all_limits(1, 1, 1, 1, 1);
            2: write_all_limits(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF);
            default: write_all_limits($urandom, $urandom_range(1, 5000000),
                                      $urandom_range(0, 3), $urandom, $urandom_range(1, 300));
         endcase
         if (phase == 5) quiet_tail = 1'b1;
         repeat (170) send_command(random_command(), 0, '0);
         wait_drained();
      end

      $display("Checked %0d frames over directed extremes and six limit settings.",
               frames_seen);
      if (mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

// ----- files.f -----
hdl/mcfp_pkg.sv
hdl/mcfp_lane.sv
hdl/mcfp_merge.sv
hdl/motor_command_frame_packer_core.sv
verif/motor_command_frame_packer_core_tb.sv
